/* hdl/srpt_pkg.sv */
// ----------------------------------------------------------------------------
// SRPT scheduler package
// Sizes, the queue entry record and the controller/datapath command and
// status groups.
// ----------------------------------------------------------------------------
package srpt_pkg;

  localparam int MAX_JOBS   = 16;
  localparam int TIME_BITS  = 16;
  localparam int ID_BITS    = 8;
  localparam int FIELD_BITS = 16;
  localparam int CNT_BITS   = $clog2(MAX_JOBS + 1);
  localparam int IDX_BITS   = $clog2(MAX_JOBS);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  typedef struct packed {
    id_t   id;
    time_t arrival;
    time_t length;
    time_t wait_cnt;
    time_t run;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic insert;
    logic age;
    logic retire;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic do_insert;
    logic scan_stop;
  } status_t;

endpackage

/* hdl/srpt_if.sv */
// ----------------------------------------------------------------------------
// SRPT scheduler channels
// Tick word channel and result word channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface srpt_in_if;
  logic        valid;
  logic        ready;
  logic        arrive_valid;
  logic [15:0] arrive_length;

  modport source (output valid, output arrive_valid, output arrive_length, input ready);
  modport sink   (input valid, input arrive_valid, input arrive_length, output ready);
endinterface

interface srpt_out_if;
  logic        valid;
  logic        ready;
  logic        done_valid;
  logic [7:0]  done_id;
  logic [15:0] done_arrival;
  logic [15:0] done_length;
  logic [15:0] done_wait;
  logic [7:0]  running_id;
  logic [4:0]  queue_count;
  logic        queue_empty;
  logic        dropped;

  modport source (output valid, output done_valid, output done_id, output done_arrival,
                  output done_length, output done_wait, output running_id,
                  output queue_count, output queue_empty, output dropped, input ready);
  modport sink   (input valid, input done_valid, input done_id, input done_arrival,
                  input done_length, input done_wait, input running_id,
                  input queue_count, input queue_empty, input dropped, output ready);
endinterface

/* hdl/srpt_ctrl.sv */
// ----------------------------------------------------------------------------
// SRPT scheduler controller
// Sequences one tick: scan for the insert position, insert, age, retire and
// hand the result word to the output register.
// ----------------------------------------------------------------------------
module srpt_ctrl import srpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_INSERT = 6'b000100,
    ST_AGE    = 6'b001000,
    ST_RETIRE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat.do_insert) begin
          state_next = ST_AGE;
        end else if (stat.scan_stop) begin
          state_next = ST_INSERT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_AGE;
      end
      ST_AGE: begin
        cmd.age    = 1'b1;
        state_next = ST_RETIRE;
      end
      ST_RETIRE: begin
        cmd.retire = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/srpt_dp.sv */
// ----------------------------------------------------------------------------
// SRPT scheduler datapath
// Ready queue held as a row of entry registers in remaining-time order, the
// scan pointer, the tick counters and the result register.
// ----------------------------------------------------------------------------
module srpt_dp import srpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     stat,
  input  logic        in_arrive,
  input  logic [15:0] in_length,
  output logic        o_done_valid,
  output logic [7:0]  o_done_id,
  output logic [15:0] o_done_arrival,
  output logic [15:0] o_done_length,
  output logic [15:0] o_done_wait,
  output logic [7:0]  o_running_id,
  output logic [4:0]  o_queue_count,
  output logic        o_queue_empty,
  output logic        o_dropped
);

  localparam time_t TMAX = '1;

  entry_t ent [MAX_JOBS];
  logic   arrive_q;
  logic   drop_q;
  time_t  len_q;
  cnt_t   ptr;
  cnt_t   count;
  time_t  cycle;
  id_t    next_id;
  logic   d_valid;
  entry_t d_ent;

  logic   full;
  logic   done_now;
  time_t  rem_head;
  time_t  rem_ptr;
  idx_t   ptr_idx;
  entry_t new_ent;

  function automatic time_t remaining(time_t l, time_t r);
    return (r >= l) ? '0 : time_t'(l - r);
  endfunction

  assign ptr_idx  = ptr[IDX_BITS-1:0];
  assign rem_head = remaining(ent[0].length, ent[0].run);
  assign rem_ptr  = remaining(ent[ptr_idx].length, ent[ptr_idx].run);
  assign full     = (count >= CNT_BITS'(MAX_JOBS));
  assign done_now = (count != '0) && (ent[0].run >= ent[0].length);

  assign stat.do_insert = arrive_q && !full;
  assign stat.scan_stop = (ptr == '0) ? ((count == '0) || (rem_head > len_q))
                                      : ((ptr >= count) || (rem_ptr >= len_q));

  assign new_ent = '{id: next_id, arrival: cycle, length: len_q, wait_cnt: '0, run: '0};

  for (genvar k = 0; k < MAX_JOBS; k++) begin : g_ent
    localparam cnt_t KC = CNT_BITS'(k);
    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (KC == ptr) begin
          ent[k] <= new_ent;
        end else if (k > 0 && KC > ptr && KC <= count) begin
          ent[k] <= ent[(k > 0) ? k - 1 : 0];
        end
      end else if (cmd.age) begin
        if (k == 0) begin
          if (count != '0 && ent[k].run < TMAX) begin
            ent[k].run <= ent[k].run + time_t'(1);
          end
        end else if (KC < count && ent[k].wait_cnt < TMAX) begin
          ent[k].wait_cnt <= ent[k].wait_cnt + time_t'(1);
        end
      end else if (cmd.retire && done_now) begin
        if (k < MAX_JOBS - 1 && KC + cnt_t'(1) < count) begin
          ent[k] <= ent[(k < MAX_JOBS - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cycle   <= time_t'(1);
      next_id <= '0;
      ptr     <= '0;
    end else begin
      if (cmd.load) begin
        ptr <= '0;
      end else if (cmd.scan_step && !stat.scan_stop) begin
        ptr <= ptr + cnt_t'(1);
      end
      if (cmd.insert) begin
        count   <= count + cnt_t'(1);
        next_id <= next_id + id_t'(1);
      end else if (cmd.retire && done_now) begin
        count <= count - cnt_t'(1);
      end
      if (cmd.emit) begin
        cycle <= cycle + time_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arrive_q <= in_arrive;
      drop_q   <= in_arrive && full;
      len_q    <= TIME_BITS'(in_length);
    end
    if (cmd.retire) begin
      d_valid <= done_now;
      d_ent   <= done_now ? ent[0] : '0;
    end
    if (cmd.emit) begin
      o_done_valid   <= d_valid;
      o_done_id      <= 8'(d_ent.id);
      o_done_arrival <= FIELD_BITS'(d_ent.arrival);
      o_done_length  <= FIELD_BITS'(d_ent.length);
      o_done_wait    <= FIELD_BITS'(d_ent.wait_cnt);
      o_running_id   <= (count != '0) ? 8'(ent[0].id) : 8'd0;
      o_queue_count  <= 5'(count);
      o_queue_empty  <= (count == '0);
      o_dropped      <= drop_q;
    end
  end

endmodule

/* hdl/srpt_scheduler_queue.sv */
// ----------------------------------------------------------------------------
// SRPT scheduler queue
// Shortest remaining processing time ready queue, one scheduler tick a word.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------------
//   in_ch    | in  | arrive_valid, arrive_length
//   out_ch   | out | done_*, running_id, queue_count, queue_empty, dropped
//
// A tick passes scan, age, retire and emit; with an insert the scan steps
// entry by entry to the insert position (at most 15) and an insert follows.
// Reset clears the counters only; no clearing pass over the queue is needed.
// A new tick is taken while the previous result word waits in the output
// register; a tick stalls only at its end if that word has not been taken.
// ----------------------------------------------------------------------------
module srpt_scheduler_queue import srpt_pkg::*; (
  input logic       clk,
  input logic       rst,
  srpt_in_if.sink   in_ch,
  srpt_out_if.source out_ch
);

  cmd_t    cmd;
  status_t stat;

  srpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srpt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_arrive      (in_ch.arrive_valid),
    .in_length      (in_ch.arrive_length),
    .o_done_valid   (out_ch.done_valid),
    .o_done_id      (out_ch.done_id),
    .o_done_arrival (out_ch.done_arrival),
    .o_done_length  (out_ch.done_length),
    .o_done_wait    (out_ch.done_wait),
    .o_running_id   (out_ch.running_id),
    .o_queue_count  (out_ch.queue_count),
    .o_queue_empty  (out_ch.queue_empty),
    .o_dropped      (out_ch.dropped)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("tick accepted while the previous one is in progress");

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> stat.do_insert)
    else $error("insert issued into a full queue");

  a_empty_running: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.queue_empty |-> out_ch.running_id == 8'd0 &&
                                           out_ch.queue_count == 5'd0)
    else $error("empty queue reports a running job");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.dropped |-> out_ch.queue_count >= 5'(MAX_JOBS - 1))
    else $error("arrival dropped while the queue had room");

endmodule

/* dv/srpt_scheduler_queue_tb.sv */
// ----------------------------------------------------------------------------
// SRPT scheduler queue testbench
// Drives scheduler ticks, with and without job arrivals, into the queue and
// checks every result word against a cycle-free model of the scheduler kept
// in this file, or against the fixed word of a pinned directed tick. A short
// table of directed ticks covers ties, preemption, zero-length jobs and a
// full queue; random ticks under varying back-pressure follow.
// ----------------------------------------------------------------------------
module srpt_scheduler_queue_tb import srpt_pkg::*; ();

  localparam int    CLK_PERIOD     = 10;
  localparam longint TIMEOUT_TIME  = 64'd200_000_000;
  localparam int    DIRECTED_ROWS  = 12;
  localparam int    ROUND_ITEMS    = 70;
  localparam int    HOLD_CYCLES    = 200;

  typedef struct packed {
    logic  done;
    id_t   id;
    time_t arrival;
    time_t length;
    time_t wait_ticks;
    id_t   running;
    cnt_t  count;
    logic  empty;
    logic  dropped;
  } tick_result_t;

  typedef struct {
    logic         arrive;
    time_t        len;
    int           reps;
    logic         settle;
    logic         pinned;
    tick_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  srpt_in_if  in_ch ();
  srpt_out_if out_ch ();

  srpt_scheduler_queue i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  entry_t sched_q [MAX_JOBS];
  cnt_t   sched_count;
  time_t  sched_cycle;
  id_t    sched_next_id;

  tick_result_t pending_words [$];
  int mismatches   = 0;
  int words_seen   = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_asks    = 0;
  int holds_served = 0;
  int hold_left    = 0;

  stim_row_t directed_rows [DIRECTED_ROWS];

  function automatic time_t rem_of(entry_t e);
    return (e.run >= e.length) ? '0 : time_t'(e.length - e.run);
  endfunction

  function automatic tick_result_t sched_tick(logic arrive, time_t len);
    tick_result_t w;
    int pos;
    int k;
    w = '0;
    if (arrive) begin
      if (sched_count >= MAX_JOBS) begin
        w.dropped = 1'b1;
      end else begin
        if (sched_count == 0 || rem_of(sched_q[0]) > len) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < sched_count && rem_of(sched_q[pos]) < len) pos++;
        end
        for (k = sched_count; k > pos; k--) sched_q[k] = sched_q[k-1];
        sched_q[pos] = '{id: sched_next_id, arrival: sched_cycle, length: len,
                         wait_cnt: '0, run: '0};
        sched_count   = sched_count + 1'b1;
        sched_next_id = sched_next_id + 1'b1;
      end
    end
    if (sched_count != 0) begin
      if (sched_q[0].run != '1) sched_q[0].run = sched_q[0].run + 1'b1;
      for (k = 1; k < sched_count; k++) begin
        if (sched_q[k].wait_cnt != '1) sched_q[k].wait_cnt = sched_q[k].wait_cnt + 1'b1;
      end
      if (sched_q[0].run >= sched_q[0].length) begin
        w.done       = 1'b1;
        w.id         = sched_q[0].id;
        w.arrival    = sched_q[0].arrival;
        w.length     = sched_q[0].length;
        w.wait_ticks = sched_q[0].wait_cnt;
        for (k = 1; k < sched_count; k++) sched_q[k-1] = sched_q[k];
        sched_count = sched_count - 1'b1;
      end
    end
    sched_cycle = sched_cycle + 1'b1;
    w.running = (sched_count != 0) ? sched_q[0].id : '0;
    w.count   = sched_count;
    w.empty   = (sched_count == 0);
    return w;
  endfunction

  function automatic tick_result_t plain_word(id_t running, cnt_t count, logic dropped);
    tick_result_t w;
    w         = '0;
    w.running = running;
    w.count   = count;
    w.empty   = (count == 0);
    w.dropped = dropped;
    return w;
  endfunction

  function automatic tick_result_t done_word(id_t id, time_t arrival, time_t length);
    tick_result_t w;
    w         = '0;
    w.done    = 1'b1;
    w.id      = id;
    w.arrival = arrival;
    w.length  = length;
    w.empty   = 1'b1;
    return w;
  endfunction

  function automatic string word_text(tick_result_t w);
    return $sformatf("done=%0d id=%0d arr=%0d len=%0d wait=%0d run_id=%0d count=%0d empty=%0d drop=%0d",
                     w.done, w.id, w.arrival, w.length, w.wait_ticks, w.running, w.count,
                     w.empty, w.dropped);
  endfunction

  task automatic push_tick(input logic arrive, input time_t len,
                           input logic pinned = 1'b0, input tick_result_t want = '0);
    tick_result_t w;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.arrive_valid  <= arrive;
    in_ch.arrive_length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    w = sched_tick(arrive, len);
    pending_words.push_back(pinned ? want : w);
  endtask

  task automatic drain_queue();
    while (sched_count != 0) push_tick(1'b0, time_t'($urandom));
  endtask

  // The receiver: random stalls per phase, and one long hold-off on request.
  always @(negedge clk) begin
    if (holds_served != hold_asks) begin
      holds_served = holds_served + 1;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left    = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_words
    tick_result_t seen;
    tick_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen.done       = out_ch.done_valid;
      seen.id         = out_ch.done_id;
      seen.arrival    = out_ch.done_arrival;
      seen.length     = out_ch.done_length;
      seen.wait_ticks = out_ch.done_wait;
      seen.running    = out_ch.running_id;
      seen.count      = out_ch.queue_count;
      seen.empty      = out_ch.queue_empty;
      seen.dropped    = out_ch.dropped;
      words_seen      = words_seen + 1;
      if (pending_words.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("Result word %0d with none expected: %s", words_seen,
                                       word_text(seen));
      end else begin
        want = pending_words.pop_front();
        if (seen !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("Result word %0d mismatch\n  expected %s\n  actual   %s", words_seen,
                     word_text(want), word_text(seen));
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_TIME);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int    round;
    int    i;
    int    n;
    int    pick;
    int    arrive_pct;
    logic  arrive;
    time_t len;

    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.arrive_valid  = 1'b0;
    in_ch.arrive_length = '0;
    out_ch.ready        = 1'b0;
    sched_count         = '0;
    sched_cycle         = time_t'(1);
    sched_next_id       = '0;

    // Ties go behind the head, and before later entries of equal remaining time;
    // a strictly shorter job preempts; the fill leaves the first job of length
    // twenty at the head when the seventeenth arrival is refused.
    directed_rows = '{
      '{1'b0, 16'd0,     1,  1'b0, 1'b1, plain_word(8'd0, 5'd0, 1'b0)},
      '{1'b1, 16'd0,     1,  1'b0, 1'b1, done_word(8'd0, 16'd2, 16'd0)},
      '{1'b1, 16'd1,     1,  1'b0, 1'b1, done_word(8'd1, 16'd3, 16'd1)},
      '{1'b1, 16'd3,     1,  1'b0, 1'b0, '0},
      '{1'b1, 16'd2,     1,  1'b0, 1'b0, '0},
      '{1'b1, 16'd1,     1,  1'b0, 1'b0, '0},
      '{1'b1, 16'd0,     1,  1'b0, 1'b0, '0},
      '{1'b1, 16'd3,     1,  1'b0, 1'b0, '0},
      '{1'b1, 16'd1,     1,  1'b0, 1'b0, '0},
      '{1'b1, 16'd20,    1,  1'b1, 1'b0, '0},
      '{1'b1, 16'd20,    15, 1'b0, 1'b0, '0},
      '{1'b1, 16'hFFFF,  1,  1'b0, 1'b1, plain_word(8'd8, 5'd16, 1'b1)}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].settle) drain_queue();
      repeat (directed_rows[i].reps) begin
        push_tick(directed_rows[i].arrive, directed_rows[i].len, directed_rows[i].pinned,
                  directed_rows[i].want);
      end
    end
    drain_queue();

    for (round = 0; round < 4; round++) begin
      case (round)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 66; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 66; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      for (i = 0; i < ROUND_ITEMS; i++) begin
        if (round == 0 && i == 40) hold_asks = hold_asks + 1;
        if ((i / 50) % 2 == 0) arrive_pct = (sched_count >= 12) ? 20 : 40;
        else arrive_pct = 15;
        arrive = ($urandom_range(99) < arrive_pct);
        pick   = $urandom_range(99);
        if (!arrive) len = time_t'($urandom);
        else if (pick < 3) len = '0;
        else if (pick < 70) len = time_t'($urandom_range(2, 1));
        else if (pick < 93) len = time_t'($urandom_range(6, 3));
        else len = time_t'($urandom_range(40, 7));
        push_tick(arrive, len);
      end
    end
    drain_queue();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    n = 0;
    while (pending_words.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (40) @(posedge clk);
    mismatches = mismatches + pending_words.size();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
